// File: design/ttm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_pkg: shared types and constants of the transit time meter
// Field widths, register indexes, reset values and the structs that pass
// between the sequencer, the history line and the top level.
// ----------------------------------------------------------------------------
package ttm_pkg;

   // field widths
   localparam int IDX_W      = 4;
   localparam int COUNT_W    = 16;
   localparam int BUDGET_W   = 24;
   localparam int PASS_W     = 3;
   localparam int LED_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // parameter defaults
   localparam int DEF_LOOPS         = 4;
   localparam int DEF_HISTORY_DEPTH = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARITY = 2'd2;

   // register reset values
   localparam logic [BUDGET_W-1:0] TIMEOUT_RST = 24'd1000000;
   localparam logic [BUDGET_W-1:0] GAP_RST     = 24'd100000;

   typedef struct packed {
      logic [BUDGET_W-1:0] timeout_ticks;
      logic [BUDGET_W-1:0] gap_ticks;
      logic                sensors_active_low;
   } cfg_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic               updated;
      logic               timed_out;
      logic [COUNT_W-1:0] viscosity_count;
      logic [LED_W-1:0]   led_code;
      logic               valves_open;
   } rslt_type;

   typedef struct packed {
      logic               shift;
      logic               load;
      logic [COUNT_W-1:0] data;
   } hist_wr_type;

endpackage
`default_nettype wire

// File: design/ttm_history.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_history: history shift line of finished measurements
// Shifts toward higher indexes on each finished measurement and returns the
// entry at the requested index as it stands after this request's update.
// ----------------------------------------------------------------------------
module ttm_history #(
   parameter int HISTORY_DEPTH = ttm_pkg::DEF_HISTORY_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire ttm_pkg::hist_wr_type       wr,
   input  wire logic [ttm_pkg::IDX_W-1:0]  rd_index,
   output logic      [ttm_pkg::COUNT_W-1:0] rd_data
);
   import ttm_pkg::*;

   // only the entries an index can reach are kept
   localparam int IDX_SPAN = 2 ** IDX_W;
   localparam int VIS      = (HISTORY_DEPTH < IDX_SPAN) ? HISTORY_DEPTH : IDX_SPAN;
   localparam int IW       = $clog2(VIS);

   logic [COUNT_W-1:0] hist_ff [VIS];
   logic [IDX_W-1:0]   rd_addr;

   // read the entry as it will stand after this shift
   always_comb begin
      rd_addr = wr.shift ? (rd_index - IDX_W'(1)) : rd_index;
      if (int'(rd_index) >= HISTORY_DEPTH) begin
         rd_data = '0;
      end else if (wr.shift && (rd_index == '0)) begin
         rd_data = wr.load ? wr.data : hist_ff[0];
      end else begin
         rd_data = hist_ff[rd_addr[IW-1:0]];
      end
   end

   // shift on a finished measurement; entry 0 holds when the key was held
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VIS; i++) hist_ff[i] <= '0;
      end else if (advance && wr.shift) begin
         for (int i = 1; i < VIS; i++) hist_ff[i] <= hist_ff[i-1];
         if (wr.load) hist_ff[0] <= wr.data;
      end
   end

endmodule
`default_nettype wire

// File: design/ttm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_core: measurement sequencer
// Wait, count and gap phases with a per-pass tick budget, pass lamps,
// accumulated count and the averaging divide, one tick per request.
// ----------------------------------------------------------------------------
module ttm_core #(
   parameter int LOOPS = ttm_pkg::DEF_LOOPS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  start_req,
   input  wire logic                  sensor_upper,
   input  wire logic                  sensor_lower,
   input  wire logic                  key_pressed,
   input  wire ttm_pkg::cfg_type      cfg,
   output ttm_pkg::rslt_type          rslt,
   output ttm_pkg::hist_wr_type       hist_wr
);
   import ttm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_WAIT  = 4'b0010,
      PH_COUNT = 4'b0100,
      PH_GAP   = 4'b1000
   } phase_type;

   // accumulator holds at most LOOPS full budgets
   localparam int ACC_W   = BUDGET_W + $clog2(LOOPS + 1);
   localparam int DIV     = 2 * LOOPS;
   localparam int DIV_L   = $clog2(DIV);
   localparam int X_W     = COUNT_W + DIV_L;
   localparam int SH      = X_W + DIV_L;
   localparam int M_W     = X_W + 1;
   localparam int PROD_W  = X_W + M_W;
   localparam longint unsigned MUL_C = ((64'd1 << SH) + DIV - 1) / DIV;
   localparam logic [ACC_W-1:0]  SAT_LIM = ACC_W'((2 ** COUNT_W) * DIV);
   localparam logic [PASS_W-1:0] LAST    = PASS_W'(LOOPS - 1);

   phase_type           phase_ff, phase_in;
   logic [PASS_W-1:0]   passes_ff, passes_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [LED_W-1:0]    leds_ff, leds_in;

   logic                up, lo, key, stop, fin, timed, start_now;
   logic [M_W-1:0]      mul_k;
   logic [X_W-1:0]      div_x;
   logic [PROD_W-1:0]   div_prod;
   logic [COUNT_W-1:0]  avg, value;

   // pass lamp: passes 0..3 light codes 1..4, higher passes keep the LEDs
   function automatic logic [LED_W-1:0] lamp(input logic [PASS_W-1:0] p,
                                             input logic [LED_W-1:0] cur);
      logic [LED_W-1:0] r;
      unique case (p)
         3'd0:    r = 3'd1;
         3'd1:    r = 3'd2;
         3'd2:    r = 3'd3;
         3'd3:    r = 3'd4;
         default: r = cur;
      endcase
      return r;
   endfunction

   assign up  = sensor_upper ^ cfg.sensors_active_low;
   assign lo  = sensor_lower ^ cfg.sensors_active_low;
   assign key = key_pressed;
   assign start_now = (phase_ff == PH_IDLE) && start_req;

   // average: reciprocal multiply, exact below the saturation limit
   assign mul_k    = M_W'(MUL_C);
   assign div_x    = acc_ff[X_W-1:0];
   assign div_prod = mul_k * div_x;
   assign avg      = (acc_ff >= SAT_LIM) ? '1 : div_prod[SH +: COUNT_W];
   assign value    = start_now ? '0 : avg;

   // one tick of the sequencer; phase changes without a decrement chain on
   always_comb begin
      phase_in  = phase_ff;
      passes_in = passes_ff;
      budget_in = budget_ff;
      acc_in    = acc_ff;
      leds_in   = leds_ff;
      stop      = 1'b0;
      fin       = 1'b0;
      timed     = 1'b0;

      // start a measurement
      if (start_now) begin
         passes_in = LAST;
         leds_in   = lamp(LAST, '0);
         acc_in    = '0;
         budget_in = cfg.timeout_ticks;
         phase_in  = PH_WAIT;
      end

      // gap: count down, then open the next pass
      if (phase_in == PH_GAP) begin
         if ((budget_in != '0) && !key) begin
            budget_in = budget_in - BUDGET_W'(1);
            stop      = 1'b1;
         end else begin
            passes_in = passes_in - PASS_W'(1);
            leds_in   = lamp(passes_in, leds_in);
            budget_in = cfg.timeout_ticks;
            phase_in  = PH_WAIT;
         end
      end

      // wait while the upper sensor is active
      if (!stop && (phase_in == PH_WAIT)) begin
         if (up && (budget_in != '0) && !key) begin
            budget_in = budget_in - BUDGET_W'(1);
            stop      = 1'b1;
         end else begin
            phase_in = PH_COUNT;
         end
      end

      // count while the lower sensor is active, then finish or pause
      if (!stop && (phase_in == PH_COUNT)) begin
         if (lo && (budget_in != '0) && !key) begin
            budget_in = budget_in - BUDGET_W'(1);
            acc_in    = acc_in + ACC_W'(1);
            stop      = 1'b1;
         end else if ((budget_in == '0) || key || (passes_in == '0)) begin
            fin      = 1'b1;
            timed    = (budget_in == '0) && !key;
            phase_in = PH_IDLE;
         end else begin
            budget_in = cfg.gap_ticks;
            phase_in  = PH_GAP;
         end
      end

      // gap just entered with the key released; a zero gap runs the
      // following passes at once, all seeing the same sensor levels
      if (!stop && (phase_in == PH_GAP)) begin
         if (cfg.gap_ticks != '0) begin
            budget_in = cfg.gap_ticks - BUDGET_W'(1);
         end else if ((cfg.timeout_ticks != '0) && up) begin
            passes_in = passes_in - PASS_W'(1);
            leds_in   = lamp(passes_in, leds_in);
            budget_in = cfg.timeout_ticks - BUDGET_W'(1);
            phase_in  = PH_WAIT;
         end else if ((cfg.timeout_ticks != '0) && lo) begin
            passes_in = passes_in - PASS_W'(1);
            leds_in   = lamp(passes_in, leds_in);
            budget_in = cfg.timeout_ticks - BUDGET_W'(1);
            acc_in    = acc_in + ACC_W'(1);
            phase_in  = PH_COUNT;
         end else if (cfg.timeout_ticks == '0) begin
            passes_in = passes_in - PASS_W'(1);
            leds_in   = lamp(passes_in, leds_in);
            budget_in = '0;
            fin       = 1'b1;
            timed     = 1'b1;
            phase_in  = PH_IDLE;
         end else begin
            passes_in = '0;
            leds_in   = lamp('0, leds_in);
            budget_in = cfg.timeout_ticks;
            fin       = 1'b1;
            phase_in  = PH_IDLE;
         end
      end
   end

   // result of this tick
   always_comb begin
      rslt.busy            = (phase_in != PH_IDLE);
      rslt.done            = fin;
      rslt.updated         = fin && !key;
      rslt.timed_out       = fin && timed;
      rslt.viscosity_count = fin ? value : '0;
      rslt.led_code        = leds_in;
      rslt.valves_open     = !((phase_in == PH_WAIT) || (phase_in == PH_COUNT));
      hist_wr.shift        = fin;
      hist_wr.load         = !key;
      hist_wr.data         = value;
   end

   // advance the state once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         passes_ff <= '0;
         budget_ff <= '0;
         acc_ff    <= '0;
         leds_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         passes_ff <= passes_in;
         budget_ff <= budget_in;
         acc_ff    <= acc_in;
         leds_ff   <= leds_in;
      end
   end

`ifndef SYNTHESIS
   a_done_goes_idle : assert property (@(posedge clock) disable iff (reset)
      advance && fin |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after a finished measurement");

   a_start_clears_acc : assert property (@(posedge clock) disable iff (reset)
      advance && start_now |=> acc_ff <= ACC_W'(1))
      else $error("accumulator not cleared at start");

   a_hold_without_request : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff) && $stable(budget_ff) && $stable(passes_ff))
      else $error("sequencer state moved without a request");
`endif

endmodule
`default_nettype wire

// File: design/transit_time_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transit_time_meter: flow-cup transit time meter, one timer tick per request
// Each request is one tick: sensor pin levels, operator key, start and a
// history index. Each request gives exactly one response with the status,
// pass LEDs, valve control, the averaged count on the finishing tick and
// the selected history entry after this tick's update.
// The response to an accepted request is registered in the response register.
// Throughput: one request per cycle while the receiver does not stall; the
// whole tick is evaluated between the request port and the response register.
// The response register parts the two sides: a new request is taken while
// the response is consumed in the same cycle; while the receiver stalls a
// held response blocks requests and the sequencer does not advance.
// The user writes registers through the csr port only while no measurement
// runs; the block does not enforce this. Reset (synchronous) returns to idle,
// clears the history, the LEDs and the count, and loads the register defaults.
// ----------------------------------------------------------------------------
module transit_time_meter #(
   parameter int LOOPS         = ttm_pkg::DEF_LOOPS,
   parameter int HISTORY_DEPTH = ttm_pkg::DEF_HISTORY_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ttm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ttm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_start_req,
   input  wire logic                            req_sensor_upper,
   input  wire logic                            req_sensor_lower,
   input  wire logic                            req_key_pressed,
   input  wire logic [ttm_pkg::IDX_W-1:0]       req_history_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic                                 rsp_updated,
   output logic                                 rsp_timed_out,
   output logic      [ttm_pkg::COUNT_W-1:0]     rsp_viscosity_count,
   output logic      [ttm_pkg::LED_W-1:0]       rsp_led_code,
   output logic                                 rsp_valves_open,
   output logic      [ttm_pkg::COUNT_W-1:0]     rsp_history_value
);
   import ttm_pkg::*;

   cfg_type            cfg_ff;
   rslt_type           rslt, rslt_ff;
   hist_wr_type        hist_wr;
   logic [COUNT_W-1:0] hist_rd, hist_rd_ff;
   logic               rsp_valid_ff;
   logic               accept;

   // take a request when the response slot is free or drains now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks      <= TIMEOUT_RST;
         cfg_ff.gap_ticks          <= GAP_RST;
         cfg_ff.sensors_active_low <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIMEOUT:  cfg_ff.timeout_ticks      <= csr_wdata;
            CSR_GAP:      cfg_ff.gap_ticks          <= csr_wdata;
            CSR_POLARITY: cfg_ff.sensors_active_low <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ttm_core #(
      .LOOPS (LOOPS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .start_req    (req_start_req),
      .sensor_upper (req_sensor_upper),
      .sensor_lower (req_sensor_lower),
      .key_pressed  (req_key_pressed),
      .cfg          (cfg_ff),
      .rslt         (rslt),
      .hist_wr      (hist_wr)
   );

   ttm_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .wr       (hist_wr),
      .rd_index (req_history_index),
      .rd_data  (hist_rd)
   );

   // response register: load on a request, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rslt_ff    <= rslt;
         hist_rd_ff <= hist_rd;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_busy_res        = rslt_ff.busy;
   assign rsp_done_res        = rslt_ff.done;
   assign rsp_updated         = rslt_ff.updated;
   assign rsp_timed_out       = rslt_ff.timed_out;
   assign rsp_viscosity_count = rslt_ff.viscosity_count;
   assign rsp_led_code        = rslt_ff.led_code;
   assign rsp_valves_open     = rslt_ff.valves_open;
   assign rsp_history_value   = hist_rd_ff;

`ifndef SYNTHESIS
   a_request_gives_response : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_stall_blocks_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while a response is held");

   a_done_is_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && rsp_valves_open)
      else $error("finished measurement still reported busy");
`endif

endmodule
`default_nettype wire

// File: verif/tb_transit_time_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transit_time_meter: self-checking bench for the transit time meter
// A queue of sensor ticks feeds a valid/ready driver. Each accepted request
// runs through a tick-accurate software meter that predicts the response.
// A monitor compares every response with the oldest prediction. Phases
// vary the budget, the gap and the pin polarity.
// ----------------------------------------------------------------------------
module tb_transit_time_meter;
   import ttm_pkg::*;

   localparam int LOOPS      = DEF_LOOPS;
   localparam int HIST_DEPTH = DEF_HISTORY_DEPTH;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WAIT  = 4'b0010,
      ST_COUNT = 4'b0100,
      ST_GAP   = 4'b1000
   } pass_state_type;

   typedef struct packed {
      logic             start;
      logic             upper;
      logic             lower;
      logic             key;
      logic [IDX_W-1:0] hidx;
   } tick_type;

   typedef struct packed {
      rslt_type           st;
      logic [COUNT_W-1:0] hist;
   } gauge_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_start_req = 1'b0;
   logic             req_sensor_upper = 1'b0;
   logic             req_sensor_lower = 1'b0;
   logic             req_key_pressed = 1'b0;
   logic [IDX_W-1:0] req_history_index = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_busy_res;
   logic               rsp_done_res;
   logic               rsp_updated;
   logic               rsp_timed_out;
   logic [COUNT_W-1:0] rsp_viscosity_count;
   logic [LED_W-1:0]   rsp_led_code;
   logic               rsp_valves_open;
   logic [COUNT_W-1:0] rsp_history_value;

   transit_time_meter #(
      .LOOPS         (LOOPS),
      .HISTORY_DEPTH (HIST_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_req       (req_start_req),
      .req_sensor_upper    (req_sensor_upper),
      .req_sensor_lower    (req_sensor_lower),
      .req_key_pressed     (req_key_pressed),
      .req_history_index   (req_history_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_updated         (rsp_updated),
      .rsp_timed_out       (rsp_timed_out),
      .rsp_viscosity_count (rsp_viscosity_count),
      .rsp_led_code        (rsp_led_code),
      .rsp_valves_open     (rsp_valves_open),
      .rsp_history_value   (rsp_history_value)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Software meter: register copies and measurement state
   // ------------------------------------------------------------------
   logic [BUDGET_W-1:0] cfg_timeout = TIMEOUT_RST;
   logic [BUDGET_W-1:0] cfg_gap     = GAP_RST;
   logic                cfg_pol     = 1'b0;

   pass_state_type      state  = ST_IDLE;
   logic [PASS_W-1:0]   passes = '0;
   logic [BUDGET_W-1:0] budget = '0;
   logic [31:0]         acc    = '0;
   logic [LED_W-1:0]    leds   = '0;
   logic [COUNT_W-1:0]  hist [HIST_DEPTH];

   tick_type          ticks_to_send [$];
   gauge_reading_type readings_due [$];
   tick_type          tick_on_bus;
   bit                item_held = 1'b0;
   int                hold_off = 0;
   int                stall_left = 0;
   int                mismatches = 0;
   int                responses = 0;
   int                cycles = 0;
   gauge_reading_type got, want;

   initial begin
      for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
   end

   // Arm a new pass: light the pass lamp and reload the budget
   function automatic void open_pass();
      case (passes)
         3'd0: begin
            leds = 3'd1;
         end
         3'd1: begin
            leds = 3'd2;
         end
         3'd2: begin
            leds = 3'd3;
         end
         3'd3: begin
            leds = 3'd4;
         end
         default: begin
         end
      endcase
      budget = cfg_timeout;
      state  = ST_WAIT;
   endfunction

   // Advance the meter by one tick and return the expected response
   function automatic gauge_reading_type meter_tick(tick_type t);
      gauge_reading_type o;
      logic              up, lo;
      logic [31:0]       avg;
      bit                stop;
      o    = '0;
      up   = t.upper ^ cfg_pol;
      lo   = t.lower ^ cfg_pol;
      stop = 1'b0;
      if (state == ST_IDLE && t.start) begin
         leds   = '0;
         passes = PASS_W'(LOOPS - 1);
         acc    = '0;
         open_pass();
      end
      for (int guard = 0; guard < 4 * LOOPS + 4 && state != ST_IDLE && !stop; guard++) begin
         case (state)
            ST_WAIT: begin
               if (up && budget != 0 && !t.key) begin
                  budget = budget - 1'b1;
                  stop = 1'b1;
               end else begin
                  state = ST_COUNT;
               end
            end
            ST_COUNT: begin
               if (lo && budget != 0 && !t.key) begin
                  budget = budget - 1'b1;
                  acc = acc + 1;
                  stop = 1'b1;
               end else if (budget == 0 || t.key || passes == 0) begin
                  // finish: average, saturate, shift history
                  avg = acc / (2 * LOOPS);
                  o.st.viscosity_count = (avg > 32'd65535) ? 16'hFFFF : avg[COUNT_W-1:0];
                  for (int i = HIST_DEPTH - 1; i >= 1; i--) hist[i] = hist[i-1];
                  if (!t.key) begin
                     hist[0] = o.st.viscosity_count;
                     o.st.updated = 1'b1;
                     o.st.timed_out = (budget == 0);
                  end
                  o.st.done = 1'b1;
                  state = ST_IDLE;
                  stop = 1'b1;
               end else begin
                  budget = cfg_gap;
                  state = ST_GAP;
               end
            end
            default: begin
               if (budget != 0 && !t.key) begin
                  budget = budget - 1'b1;
                  stop = 1'b1;
               end else begin
                  passes = passes - 1'b1;
                  open_pass();
               end
            end
         endcase
      end
      o.st.busy        = (state != ST_IDLE);
      o.st.led_code    = leds;
      o.st.valves_open = !(state == ST_WAIT || state == ST_COUNT);
      o.hist           = (t.hidx < HIST_DEPTH) ? hist[t.hidx] : '0;
      return o;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on acceptance
         if (req_valid && req_ready) begin
            readings_due.push_back(meter_tick(tick_on_bus));
            item_held = 1'b0;
         end
         // refill the slot once it is free
         if (!req_valid || req_ready) begin
            if (hold_off > 0) begin
               hold_off--;
               req_valid <= 1'b0;
            end else if (ticks_to_send.size() > 0) begin
               tick_on_bus = ticks_to_send.pop_front();
               item_held = 1'b1;
               req_start_req <= tick_on_bus.start;
               req_sensor_upper <= tick_on_bus.upper;
               req_sensor_lower <= tick_on_bus.lower;
               req_key_pressed <= tick_on_bus.key;
               req_history_index <= tick_on_bus.hidx;
               req_valid <= 1'b1;
               hold_off = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver with random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   task automatic show_reading(string tag, gauge_reading_type r);
      $display("  %s busy=%b done=%b upd=%b tmo=%b count=%0d led=%0d valves=%b hist=%0d",
               tag, r.st.busy, r.st.done, r.st.updated, r.st.timed_out,
               r.st.viscosity_count, r.st.led_code, r.st.valves_open, r.hist);
   endtask

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_busy_res, rsp_done_res, rsp_updated, rsp_timed_out,
                rsp_viscosity_count, rsp_led_code, rsp_valves_open, rsp_history_value};
         responses++;
         if (readings_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d arrived with no request outstanding", responses);
               show_reading("actual  ", got);
            end
         end else begin
            want = readings_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d mismatch", responses);
                  show_reading("expected", want);
                  show_reading("actual  ", got);
               end
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic void push_tick(logic start, logic up, logic lo, logic key,
                                     logic [IDX_W-1:0] idx);
      tick_type t;
      t = '{start: start, upper: up, lower: lo, key: key, hidx: idx};
      ticks_to_send.push_back(t);
   endfunction

   // Drain all traffic, then abort any open measurement with the key
   task automatic settle();
      while (ticks_to_send.size() != 0 || item_held || readings_due.size() != 0)
         @(posedge clock);
      while (state != ST_IDLE) begin
         push_tick(1'b0, 1'b0, 1'b0, 1'b1, IDX_W'($urandom));
         while (ticks_to_send.size() != 0 || item_held || readings_due.size() != 0)
            @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TIMEOUT: begin
            cfg_timeout = val;
         end
         CSR_GAP: begin
            cfg_gap = val;
         end
         CSR_POLARITY: begin
            cfg_pol = val[0];
         end
         default: begin
         end
      endcase
   endtask

   // Measurement-shaped traffic: per pass an upper stretch, a lower stretch
   // and a gap, with sensor noise, stray starts, key presses and bursts of
   // random ticks in between.
   task automatic random_traffic(int n, int up_max, int lo_max, int key_pct);
      int  sent, len;
      bit  long_gap;
      logic up_on, lo_on;
      sent = 0;
      long_gap = (cfg_gap > 30);
      while (sent < n) begin
         if ($urandom_range(0, 99) < 15) begin
            len = $urandom_range(1, 6);
            repeat (len) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                                   IDX_W'($urandom));
            sent += len;
         end else begin
            push_tick(1'b1, 1'($urandom_range(0, 1)) ^ cfg_pol, 1'b1 ^ cfg_pol, 1'b0,
                      IDX_W'($urandom));
            sent++;
            for (int p = 0; p < LOOPS; p++) begin
               for (int seg = 0; seg < 3; seg++) begin
                  if (seg == 0) len = $urandom_range(0, up_max);
                  else if (seg == 1) len = $urandom_range(0, lo_max);
                  else if (long_gap) len = $urandom_range(1, 8);
                  else len = cfg_gap + $urandom_range(0, 2);
                  up_on = (seg == 0);
                  lo_on = (seg != 2);
                  for (int k = 0; k < len; k++) begin
                     push_tick($urandom_range(0, 39) == 0,
                               up_on ^ cfg_pol ^ ($urandom_range(0, 24) == 0),
                               lo_on ^ cfg_pol ^ ($urandom_range(0, 24) == 0),
                               $urandom_range(0, 99) < key_pct, IDX_W'($urandom));
                     sent++;
                  end
                  // cut a long pause short with the key
                  if (seg == 2 && long_gap) begin
                     push_tick(1'b0, cfg_pol, cfg_pol, 1'b1, IDX_W'($urandom));
                     sent++;
                  end
               end
            end
            len = $urandom_range(0, 3);
            repeat (len) push_tick(1'b0, cfg_pol, cfg_pol, 1'b0, IDX_W'($urandom));
            sent += len;
         end
      end
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: key in the gap ends the run, start on the done tick is
      // ignored, start with the key held finishes at once
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
      push_tick(1'b1, 1'b1, 1'b1, 1'b0, 4'd15);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd10);
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd5);
      push_tick(1'b1, 1'b0, 1'b0, 1'b1, 4'd1);
      push_tick(1'b1, 1'b1, 1'b1, 1'b1, 4'd2);
      settle();

      // short budget: timeout while waiting, start while busy, full run
      write_reg(CSR_TIMEOUT, 24'd3);
      write_reg(CSR_GAP, 24'd1);
      write_reg(CSR_POLARITY, 24'd0);
      push_tick(1'b1, 1'b1, 1'b1, 1'b0, 4'd0);
      push_tick(1'b1, 1'b1, 1'b0, 1'b0, 4'd1);
      push_tick(1'b0, 1'b1, 1'b0, 1'b0, 4'd2);
      push_tick(1'b0, 1'b1, 1'b1, 1'b0, 4'd3);
      push_tick(1'b1, 1'b0, 1'b1, 1'b0, 4'd0);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd1);
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd3);
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd4);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd5);
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd6);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd7);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd8);
      push_tick(1'b0, 1'b0, 1'b1, 1'b0, 4'd9);
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd14);
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'd15);
      settle();

      // random phases across budget, gap and polarity settings
      write_reg(CSR_TIMEOUT, 24'd12);
      write_reg(CSR_GAP, 24'd3);
      random_traffic(500, 16, 14, 1);

      write_reg(CSR_TIMEOUT, 24'd1);
      write_reg(CSR_GAP, 24'd0);
      write_reg(CSR_POLARITY, 24'd1);
      random_traffic(250, 3, 3, 2);

      // zero budget: the first pass times out at once and ends the measurement
      write_reg(CSR_TIMEOUT, 24'd0);
      write_reg(CSR_GAP, 24'd5);
      write_reg(CSR_POLARITY, 24'd0);
      random_traffic(150, 4, 4, 2);

      write_reg(CSR_TIMEOUT, 24'hFFFFFF);
      write_reg(CSR_GAP, 24'hFFFFFF);
      write_reg(CSR_POLARITY, 24'd1);
      random_traffic(300, 20, 30, 3);

      write_reg(CSR_TIMEOUT, 24'd40);
      write_reg(CSR_GAP, 24'd8);
      random_traffic(600, 30, 45, 1);

      repeat (10) @(posedge clock);
      if (mismatches == 0 && readings_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
